[hdl/tcct_pkg.sv]
// shared types, constants and helpers for the three-channel compare timer
// no dependencies; used by the interfaces, the top level and the checker
package tcct_pkg;

    localparam int CHANNEL_COUNT_DEF = 3;
    localparam int KIND_W = 2;
    localparam int OFF_W  = 5;
    localparam int DATA_W = 8;
    localparam int VEC_W  = 6;
    localparam int CNT_W  = 16;
    localparam int TICK_W = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_READ  = 2'd2
    } t_kind;

    // offsets inside the common window
    localparam logic [2:0] OFF_START    = 3'd0;
    localparam logic [2:0] OFF_STAT_A   = 3'd4;
    localparam logic [2:0] OFF_STAT_B   = 3'd5;
    localparam logic [2:0] OFF_STAT_OVF = 3'd6;

    // offsets inside a channel window
    localparam logic [2:0] SUB_CONTROL = 3'd0;
    localparam logic [2:0] SUB_CNT_HI  = 3'd2;
    localparam logic [2:0] SUB_CNT_LO  = 3'd3;
    localparam logic [2:0] SUB_CMPA_HI = 3'd4;
    localparam logic [2:0] SUB_CMPA_LO = 3'd5;
    localparam logic [2:0] SUB_CMPB_HI = 3'd6;
    localparam logic [2:0] SUB_CMPB_LO = 3'd7;

    localparam logic [DATA_W-1:0] START_RST   = 8'hf8;
    localparam logic [DATA_W-1:0] STATUS_RST  = 8'h88;
    localparam logic [DATA_W-1:0] CONTROL_RST = 8'h80;

    // control bits 6:5 select the clearing compare
    localparam logic [1:0] CLR_ON_A = 2'b01;
    localparam logic [1:0] CLR_ON_B = 2'b10;

    localparam logic [VEC_W-1:0] VEC_NONE = 6'd0;
    localparam logic [VEC_W-1:0] VEC_BASE = 6'd24;
    localparam logic [VEC_W-1:0] VEC_LAST = 6'd34;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OFF_W-1:0]  reg_offset;
        logic [DATA_W-1:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [VEC_W-1:0]  irq_vector;
    } t_out_item;

    // channel counts on this tick when the tick count is a multiple of its prescale
    function automatic logic prescale_hit(input logic [TICK_W-1:0] tick,
                                          input logic [DATA_W-1:0] ctl);
        logic [2:0]        expo;
        logic [TICK_W-1:0] mask;
        expo = {1'b0, ctl[1:0]} + {2'b00, ~ctl[4]};
        mask = ~(4'hf << expo);
        return (tick & mask) == '0;
    endfunction

endpackage

[hdl/tcct_if.sv]
// valid/ready channel interfaces for the compare timer
// depends on tcct_pkg for the payload structs
interface tcct_in_if import tcct_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface tcct_out_if import tcct_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hdl/three_channel_compare_timer_top.sv]
// path: a taken beat waits in the input register, then in the result register
// throughput: one beat per cycle; the input register empties whenever the
//   result register is free or being taken in the same cycle
// reset: synchronous active-low i_rst_n empties both registers and restores all
//   timer registers to their reset values
// depends on tcct_pkg and tcct_if
module three_channel_compare_timer_top import tcct_pkg::*; #(
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcct_in_if.sink       i_item,
    tcct_out_if.source    o_result
);

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;

    logic [DATA_W-1:0] r_start, n_start;
    logic [DATA_W-1:0] r_stat_a, n_stat_a;
    logic [DATA_W-1:0] r_stat_b, n_stat_b;
    logic [DATA_W-1:0] r_stat_ovf, n_stat_ovf;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [DATA_W-1:0] r_ctl [CHANNEL_COUNT];
    logic [DATA_W-1:0] n_ctl [CHANNEL_COUNT];
    logic [CNT_W-1:0]  r_cnt [CHANNEL_COUNT];
    logic [CNT_W-1:0]  n_cnt [CHANNEL_COUNT];
    logic [CNT_W-1:0]  r_cmpa [CHANNEL_COUNT];
    logic [CNT_W-1:0]  n_cmpa [CHANNEL_COUNT];
    logic [CNT_W-1:0]  r_cmpb [CHANNEL_COUNT];
    logic [CNT_W-1:0]  n_cmpb [CHANNEL_COUNT];

    logic              proc;
    logic              in_take;
    logic [DATA_W-1:0] rd;
    logic [VEC_W-1:0]  vec;

    assign proc     = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_take  = i_item.valid && i_item.ready;
    assign i_item.ready   = !r_in_valid || proc;
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out;

    always_comb begin
        logic [CNT_W-1:0] cnt;
        logic             wrap;
        logic [2:0]       sub;
        logic             win0;
        cnt  = '0;
        wrap = 1'b0;
        sub  = r_in.reg_offset[2:0];
        win0 = r_in.reg_offset[4:3] == 2'd0;
        n_start    = r_start;
        n_stat_a   = r_stat_a;
        n_stat_b   = r_stat_b;
        n_stat_ovf = r_stat_ovf;
        n_tick     = r_tick;
        rd         = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++) begin
            n_ctl[c]  = r_ctl[c];
            n_cnt[c]  = r_cnt[c];
            n_cmpa[c] = r_cmpa[c];
            n_cmpb[c] = r_cmpb[c];
        end
        if (proc) begin
            unique case (r_in.kind)
                KIND_TICK: begin
                    n_tick = r_tick + 1'b1;
                    for (int c = 0; c < CHANNEL_COUNT; c++) begin
                        if (r_start[c] && prescale_hit(n_tick, r_ctl[c])) begin
                            cnt  = r_cnt[c] + 1'b1;
                            wrap = &r_cnt[c];
                            if (cnt == r_cmpa[c]) begin
                                n_stat_a[c] = 1'b1;
                                if (r_ctl[c][6:5] == CLR_ON_A) cnt = '0;
                            end
                            // compare B sees the value after a clear by A
                            if (cnt == r_cmpb[c]) begin
                                n_stat_b[c] = 1'b1;
                                if (r_ctl[c][6:5] == CLR_ON_B) cnt = '0;
                            end
                            if (wrap) n_stat_ovf[c] = 1'b1;
                            n_cnt[c] = cnt;
                        end
                    end
                end
                KIND_WRITE: begin
                    if (win0) begin
                        unique case (sub)
                            OFF_START:    n_start    = r_in.write_data;
                            OFF_STAT_A:   n_stat_a   = r_in.write_data;
                            OFF_STAT_B:   n_stat_b   = r_in.write_data;
                            OFF_STAT_OVF: n_stat_ovf = r_in.write_data;
                            default: ;
                        endcase
                    end
                    for (int c = 0; c < CHANNEL_COUNT; c++) begin
                        if (r_in.reg_offset[4:3] == 2'(c + 1)) begin
                            unique case (sub)
                                SUB_CONTROL: n_ctl[c]        = r_in.write_data;
                                SUB_CNT_HI:  n_cnt[c][15:8]  = r_in.write_data;
                                SUB_CNT_LO:  n_cnt[c][7:0]   = r_in.write_data;
                                SUB_CMPA_HI: n_cmpa[c][15:8] = r_in.write_data;
                                SUB_CMPA_LO: n_cmpa[c][7:0]  = r_in.write_data;
                                SUB_CMPB_HI: n_cmpb[c][15:8] = r_in.write_data;
                                SUB_CMPB_LO: n_cmpb[c][7:0]  = r_in.write_data;
                                default: ;
                            endcase
                        end
                    end
                end
                KIND_READ: begin
                    if (win0) begin
                        unique case (sub)
                            OFF_START:    rd = r_start;
                            OFF_STAT_A:   rd = r_stat_a;
                            OFF_STAT_B:   rd = r_stat_b;
                            OFF_STAT_OVF: rd = r_stat_ovf;
                            default:      rd = '0;
                        endcase
                    end
                    for (int c = 0; c < CHANNEL_COUNT; c++) begin
                        if (r_in.reg_offset[4:3] == 2'(c + 1)) begin
                            unique case (sub)
                                SUB_CONTROL: rd = r_ctl[c];
                                SUB_CNT_HI:  rd = r_cnt[c][15:8];
                                SUB_CNT_LO:  rd = r_cnt[c][7:0];
                                SUB_CMPA_HI: rd = r_cmpa[c][15:8];
                                SUB_CMPA_LO: rd = r_cmpa[c][7:0];
                                SUB_CMPB_HI: rd = r_cmpb[c][15:8];
                                SUB_CMPB_LO: rd = r_cmpb[c][7:0];
                                default:     rd = '0;
                            endcase
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // lowest channel wins, and within a channel A, then B, then overflow
    always_comb begin
        vec = VEC_NONE;
        for (int c = CHANNEL_COUNT - 1; c >= 0; c--) begin
            if (n_stat_ovf[c + 4] && n_stat_ovf[c]) vec = VEC_BASE + 6'(4 * c + 2);
            if (n_stat_b[c + 4] && n_stat_b[c])     vec = VEC_BASE + 6'(4 * c + 1);
            if (n_stat_a[c + 4] && n_stat_a[c])     vec = VEC_BASE + 6'(4 * c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_start     <= START_RST;
            r_stat_a    <= STATUS_RST;
            r_stat_b    <= STATUS_RST;
            r_stat_ovf  <= STATUS_RST;
            r_tick      <= '0;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_ctl[c]  <= CONTROL_RST;
                r_cnt[c]  <= '0;
                r_cmpa[c] <= '0;
                r_cmpb[c] <= '0;
            end
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            r_start    <= n_start;
            r_stat_a   <= n_stat_a;
            r_stat_b   <= n_stat_b;
            r_stat_ovf <= n_stat_ovf;
            r_tick     <= n_tick;
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_ctl[c]  <= n_ctl[c];
                r_cnt[c]  <= n_cnt[c];
                r_cmpa[c] <= n_cmpa[c];
                r_cmpb[c] <= n_cmpb[c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_item.data;
        end
        if (proc) begin
            r_out.read_data  <= rd;
            r_out.irq_vector <= vec;
        end
    end

endmodule

[hdl/tcct_checker.sv]
// port-level checks for the compare timer, bound to the top level
// depends on tcct_pkg and three_channel_compare_timer_top
module tcct_checker import tcct_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [VEC_W-1:0] i_irq_vector
);

    logic [1:0] r_pending;
    logic [1:0] n_pending;
    logic       in_beat;
    logic       out_beat;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    always_comb begin
        n_pending = r_pending + 2'(in_beat) - 2'(out_beat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    // a result only for a beat that was taken
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pending != 2'd0)
        else $error("result shown with no beat outstanding");

    // at most one beat in the input register and one in the result register
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 2'd2)
        else $error("more than two beats outstanding");

    // vectors are zero or an A, B or overflow slot of some channel
    a_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_irq_vector == VEC_NONE) ||
            ((i_irq_vector >= VEC_BASE) && (i_irq_vector <= VEC_LAST) &&
             (i_irq_vector[1:0] != 2'd3)))
        else $error("illegal interrupt vector");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_irq_vector))
        else $error("stalled result dropped or changed");

endmodule

bind three_channel_compare_timer_top tcct_checker u_tcct_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_item.valid),
    .i_in_ready   (i_item.ready),
    .i_out_valid  (o_result.valid),
    .i_out_ready  (o_result.ready),
    .i_irq_vector (o_result.data.irq_vector)
);
